@@ rtl/chtbl_pkg.sv @@
// ----------------------------------------------------------------------------
// chtbl_pkg
// Shared sizes, codes and word types of the chained hash table.
// ----------------------------------------------------------------------------
package chtbl_pkg;

    localparam int BUCKETS   = 1024;
    localparam int NODES     = 1024;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int STAT_W    = 2;
    localparam int OUT_BKT_W = 10;

    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int NODE_W    = $clog2(NODES);
    // node pointer: one extra bit, set only in the null code
    localparam int PTR_W     = NODE_W + 1;
    localparam logic [PTR_W-1:0] NIL_PTR = {1'b1, {NODE_W{1'b0}}};

    localparam int CLR_N     = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLR_W     = $clog2(CLR_N);

    localparam bit BKT_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

    // key reduction for other bucket counts: multiply, scale back, subtract
    localparam int MOD_STEPS = 3;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);
    localparam int RCP_SH    = KEY_W + BKT_W;
    localparam int RCP_W     = KEY_W + 1;
    localparam int PROD_W    = KEY_W + RCP_W;
    localparam logic [63:0] RCP_NUM = (64'd1 << RCP_SH) + 64'(BUCKETS) - 64'd1;
    localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'(RCP_NUM / 64'(BUCKETS));

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_INS_RD,
        S_INS_WR,
        S_LOOK_RD,
        S_LOOK_LD,
        S_NODE_RD,
        S_NODE_CHK,
        S_UNLINK,
        S_FREE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_BKT_W-1:0] bucket;
    } rsp_word_t;

    typedef struct packed {
        logic              clr_step;
        logic              accept;
        logic              mod_step;
        logic              ins_rd;
        logic              ins_wr;
        logic              look_ld;
        logic              node_adv;
        logic              hold_link;
        logic              unlink;
        logic              free_node;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic            mod_done;
        logic [OP_W-1:0] op;
        logic            free_empty;
        logic            cur_end;
        logic            key_match;
        logic            out_free;
    } sts_t;

endpackage

@@ rtl/chtbl_ram.sv @@
// ----------------------------------------------------------------------------
// chtbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/chtbl_ctrl.sv @@
// ----------------------------------------------------------------------------
// chtbl_ctrl
// Sequencer: clearing pass, bucket reduction, chain walk and list updates.
// ----------------------------------------------------------------------------
module chtbl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  chtbl_pkg::sts_t   sts,
    output chtbl_pkg::cmd_t   cmd
);

    chtbl_pkg::state_t state_reg;
    chtbl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chtbl_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            chtbl_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = chtbl_pkg::S_IDLE;
                end
            end
            chtbl_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = chtbl_pkg::S_MOD;
                end
            end
            chtbl_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    priority if (sts.op == chtbl_pkg::OP_INSERT)
                    begin
                        if (sts.free_empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = chtbl_pkg::STAT_FULL;
                            state_next     = chtbl_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = chtbl_pkg::S_INS_RD;
                        end
                    end
                    else if (sts.op == chtbl_pkg::OP_SEARCH ||
                             sts.op == chtbl_pkg::OP_REMOVE)
                    begin
                        state_next = chtbl_pkg::S_LOOK_RD;
                    end
                    else
                    begin
                        // unused code: report not found, touch nothing
                        cmd.set_status = 1'b1;
                        cmd.status     = chtbl_pkg::STAT_NOT_FOUND;
                        state_next     = chtbl_pkg::S_DONE;
                    end
                end
            end
            chtbl_pkg::S_INS_RD:
            begin
                cmd.ins_rd = 1'b1;
                state_next = chtbl_pkg::S_INS_WR;
            end
            chtbl_pkg::S_INS_WR:
            begin
                cmd.ins_wr     = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = chtbl_pkg::STAT_OK;
                state_next     = chtbl_pkg::S_DONE;
            end
            chtbl_pkg::S_LOOK_RD:
            begin
                state_next = chtbl_pkg::S_LOOK_LD;
            end
            chtbl_pkg::S_LOOK_LD:
            begin
                cmd.look_ld = 1'b1;
                state_next  = chtbl_pkg::S_NODE_RD;
            end
            chtbl_pkg::S_NODE_RD:
            begin
                if (sts.cur_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = chtbl_pkg::STAT_NOT_FOUND;
                    state_next     = chtbl_pkg::S_DONE;
                end
                else
                begin
                    state_next = chtbl_pkg::S_NODE_CHK;
                end
            end
            chtbl_pkg::S_NODE_CHK:
            begin
                if (sts.key_match)
                begin
                    if (sts.op == chtbl_pkg::OP_REMOVE)
                    begin
                        cmd.hold_link = 1'b1;
                        state_next    = chtbl_pkg::S_UNLINK;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = chtbl_pkg::STAT_OK;
                        state_next     = chtbl_pkg::S_DONE;
                    end
                end
                else
                begin
                    cmd.node_adv = 1'b1;
                    state_next   = chtbl_pkg::S_NODE_RD;
                end
            end
            chtbl_pkg::S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = chtbl_pkg::S_FREE;
            end
            chtbl_pkg::S_FREE:
            begin
                cmd.free_node  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = chtbl_pkg::STAT_OK;
                state_next     = chtbl_pkg::S_DONE;
            end
            chtbl_pkg::S_DONE:
            begin
                // hold until the output word slot frees up
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = chtbl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chtbl_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/chtbl_dpath.sv @@
// ----------------------------------------------------------------------------
// chtbl_dpath
// Bucket heads, node keys and node links memories, walk registers, free
// list head, bucket reduction and the output word register.
// ----------------------------------------------------------------------------
module chtbl_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  chtbl_pkg::req_word_t  req_word,
    input  chtbl_pkg::cmd_t       cmd,
    output chtbl_pkg::sts_t       sts,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output chtbl_pkg::rsp_word_t  rsp_word
);

    logic [chtbl_pkg::OP_W-1:0]      op_reg;
    logic [chtbl_pkg::KEY_W-1:0]     key_reg;
    logic [chtbl_pkg::BKT_W-1:0]     bucket_reg;
    logic [chtbl_pkg::MOD_CNT_W-1:0] mod_cnt_reg;
    logic [chtbl_pkg::PROD_W-1:0]    prod_reg;
    logic [chtbl_pkg::KEY_W-1:0]     qd_reg;
    logic [chtbl_pkg::CLR_W-1:0]     clr_reg;
    logic [chtbl_pkg::PTR_W-1:0]     cur_reg;
    logic [chtbl_pkg::PTR_W-1:0]     prev_reg;
    logic [chtbl_pkg::NODE_W:0]      steps_reg;
    logic [chtbl_pkg::PTR_W-1:0]     link_cur_reg;
    logic [chtbl_pkg::PTR_W-1:0]     free_head_reg;
    logic [chtbl_pkg::STAT_W-1:0]    status_reg;
    logic                            rsp_valid_reg;
    chtbl_pkg::rsp_word_t            rsp_reg;

    logic                            head_we;
    logic [chtbl_pkg::BKT_W-1:0]     head_waddr;
    logic [chtbl_pkg::PTR_W-1:0]     head_wdata;
    logic [chtbl_pkg::PTR_W-1:0]     head_q;

    logic                            link_we;
    logic [chtbl_pkg::NODE_W-1:0]    link_waddr;
    logic [chtbl_pkg::PTR_W-1:0]     link_wdata;
    logic [chtbl_pkg::NODE_W-1:0]    link_raddr;
    logic [chtbl_pkg::PTR_W-1:0]     link_q;

    logic [chtbl_pkg::KEY_W-1:0]     key_q;

    logic                            clr_in_bkt;
    logic                            clr_in_node;
    logic                            clr_node_last;

    logic [chtbl_pkg::KEY_W-1:0]     quot;
    logic [chtbl_pkg::BKT_W+chtbl_pkg::OUT_BKT_W-1:0] bucket_wide;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    chtbl_ram #(
        .WIDTH (chtbl_pkg::PTR_W),
        .DEPTH (chtbl_pkg::BUCKETS)
    ) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket_reg),
        .rdata (head_q)
    );

    chtbl_ram #(
        .WIDTH (chtbl_pkg::PTR_W),
        .DEPTH (chtbl_pkg::NODES)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    chtbl_ram #(
        .WIDTH (chtbl_pkg::KEY_W),
        .DEPTH (chtbl_pkg::NODES)
    ) u_keys (
        .clk   (clk),
        .we    (cmd.ins_wr),
        .waddr (free_head_reg[chtbl_pkg::NODE_W-1:0]),
        .wdata (key_reg),
        .raddr (cur_reg[chtbl_pkg::NODE_W-1:0]),
        .rdata (key_q)
    );

    // ------------------------------------------------------------------
    // clearing pass and write port selection
    // ------------------------------------------------------------------
    assign clr_in_bkt    = ({1'b0, clr_reg} < (chtbl_pkg::CLR_W+1)'(chtbl_pkg::BUCKETS));
    assign clr_in_node   = ({1'b0, clr_reg} < (chtbl_pkg::CLR_W+1)'(chtbl_pkg::NODES));
    assign clr_node_last = ({1'b0, clr_reg} == (chtbl_pkg::CLR_W+1)'(chtbl_pkg::NODES - 1));

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = chtbl_pkg::NIL_PTR;
        if (cmd.clr_step)
        begin
            head_we    = clr_in_bkt;
            head_waddr = clr_reg[chtbl_pkg::BKT_W-1:0];
        end
        else if (cmd.ins_wr)
        begin
            head_we    = 1'b1;
            head_wdata = free_head_reg;
        end
        else if (cmd.unlink && prev_reg[chtbl_pkg::NODE_W])
        begin
            // match at chain head: bypass it in the bucket
            head_we    = 1'b1;
            head_wdata = link_cur_reg;
        end
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = cur_reg[chtbl_pkg::NODE_W-1:0];
        link_wdata = free_head_reg;
        if (cmd.clr_step)
        begin
            link_we    = clr_in_node;
            link_waddr = clr_reg[chtbl_pkg::NODE_W-1:0];
            link_wdata = clr_node_last ? chtbl_pkg::NIL_PTR
                                       : chtbl_pkg::PTR_W'(clr_reg) + chtbl_pkg::PTR_W'(1);
        end
        else if (cmd.ins_wr)
        begin
            link_we    = 1'b1;
            link_waddr = free_head_reg[chtbl_pkg::NODE_W-1:0];
            link_wdata = head_q;
        end
        else if (cmd.unlink && !prev_reg[chtbl_pkg::NODE_W])
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg[chtbl_pkg::NODE_W-1:0];
            link_wdata = link_cur_reg;
        end
        else if (cmd.free_node)
        begin
            link_we = 1'b1;
        end
    end

    assign link_raddr = cmd.ins_rd ? free_head_reg[chtbl_pkg::NODE_W-1:0]
                                   : cur_reg[chtbl_pkg::NODE_W-1:0];

    // ------------------------------------------------------------------
    // bucket reduction: reciprocal multiply for the quotient, then
    // subtract quotient times bucket count from the key
    // ------------------------------------------------------------------
    assign quot = chtbl_pkg::KEY_W'(prod_reg >> chtbl_pkg::RCP_SH);

    assign bucket_wide = {{chtbl_pkg::OUT_BKT_W{1'b0}}, bucket_reg};

    // ------------------------------------------------------------------
    // status
    // ------------------------------------------------------------------
    assign sts.clr_last   = (clr_reg == chtbl_pkg::CLR_W'(chtbl_pkg::CLR_N - 1));
    assign sts.mod_done   = chtbl_pkg::BKT_POW2 ||
                            (mod_cnt_reg == chtbl_pkg::MOD_CNT_W'(chtbl_pkg::MOD_STEPS - 1));
    assign sts.op         = op_reg;
    assign sts.free_empty = free_head_reg[chtbl_pkg::NODE_W];
    assign sts.cur_end    = cur_reg[chtbl_pkg::NODE_W] ||
                            (steps_reg == (chtbl_pkg::NODE_W+1)'(chtbl_pkg::NODES));
    assign sts.key_match  = (key_q == key_reg);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + chtbl_pkg::CLR_W'(1);
            end
            if (cmd.ins_wr)
            begin
                free_head_reg <= link_q;
            end
            else if (cmd.free_node)
            begin
                free_head_reg <= cur_reg;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= req_word.operation;
            key_reg     <= req_word.key;
            bucket_reg  <= chtbl_pkg::BKT_POW2 ? req_word.key[chtbl_pkg::BKT_W-1:0] : '0;
            mod_cnt_reg <= '0;
        end
        else if (cmd.mod_step && !chtbl_pkg::BKT_POW2)
        begin
            priority if (mod_cnt_reg == '0)
            begin
                prod_reg <= chtbl_pkg::PROD_W'(key_reg) * chtbl_pkg::PROD_W'(chtbl_pkg::RCP_MUL);
            end
            else if (mod_cnt_reg == chtbl_pkg::MOD_CNT_W'(1))
            begin
                qd_reg <= quot * chtbl_pkg::KEY_W'(chtbl_pkg::BUCKETS);
            end
            else
            begin
                bucket_reg <= chtbl_pkg::BKT_W'(key_reg - qd_reg);
            end
            if (!sts.mod_done)
            begin
                mod_cnt_reg <= mod_cnt_reg + chtbl_pkg::MOD_CNT_W'(1);
            end
        end
        if (cmd.look_ld)
        begin
            cur_reg   <= head_q;
            prev_reg  <= chtbl_pkg::NIL_PTR;
            steps_reg <= '0;
        end
        else if (cmd.node_adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_q;
            steps_reg <= steps_reg + (chtbl_pkg::NODE_W+1)'(1);
        end
        if (cmd.hold_link)
        begin
            link_cur_reg <= link_q;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.load_out)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.bucket <= (status_reg == chtbl_pkg::STAT_OK)
                              ? bucket_wide[chtbl_pkg::OUT_BKT_W-1:0] : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

@@ rtl/chained_hash_table.sv @@
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
//   channel   handshake              word                   role
//   req       req_valid / req_stall  req_word (op, key)     insert/search/remove
//   rsp       rsp_valid / rsp_stall  rsp_word (status, bkt) one word per request
//
// An insert runs the bucket reduction, reads the free list head's link and
// writes the new node and its bucket head. A search or remove loads the
// bucket head, then walks the chain with one read of the keys/links memories
// per node; a remove that hits then unlinks and frees the node. A bucket
// count that is not a power of two adds the reciprocal key reduction.
// After reset a clearing pass over max(BUCKETS, NODES) = 1024 addresses
// initializes bucket heads and the free list; req_stall stays high meanwhile.
// A result held by rsp_stall does not block accepting the next request.
// ----------------------------------------------------------------------------
module chained_hash_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  chtbl_pkg::req_word_t  req_word,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output chtbl_pkg::rsp_word_t  rsp_word
);

    chtbl_pkg::cmd_t cmd;
    chtbl_pkg::sts_t sts;

    chtbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    chtbl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

    // no request is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> req_stall)
        else $error("request accepted during clearing pass");

    // a result never overwrites a word still waiting on the output
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid || !rsp_stall))
        else $error("output word overwritten while stalled");

    // insert writes only with a node on the free list
    a_insert_has_node: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |-> !sts.free_empty)
        else $error("insert with empty node pool");

    // an accepted request produces no result in the very next cycle
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !cmd.load_out)
        else $error("result loaded right after accept");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the chained hash table against a software copy of its buckets, node
// pool and free list. Directed words cover an empty table, collisions,
// duplicates and the unused opcode. Random phases follow: a mixed phase, a
// gap-free pool fill and a remove-heavy drain. Elsewhere both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [chtbl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    class chain_scoreboard;
        logic [chtbl_pkg::PTR_W-1:0] head_of_bucket [chtbl_pkg::BUCKETS];
        logic [chtbl_pkg::KEY_W-1:0] key_of_node [chtbl_pkg::NODES];
        logic [chtbl_pkg::PTR_W-1:0] link_of_node [chtbl_pkg::NODES];
        logic [chtbl_pkg::PTR_W-1:0] free_list_head;
        chtbl_pkg::rsp_word_t        awaited [$];
        int                          mismatches;

        function new();
            mismatches = 0;
            for (int b = 0; b < chtbl_pkg::BUCKETS; b++)
            begin
                head_of_bucket[b] = chtbl_pkg::NIL_PTR;
            end
            for (int n = 0; n < chtbl_pkg::NODES; n++)
            begin
                key_of_node[n]  = '0;
                link_of_node[n] = (n + 1 < chtbl_pkg::NODES) ? chtbl_pkg::PTR_W'(n + 1)
                                                            : chtbl_pkg::NIL_PTR;
            end
            free_list_head = '0;
        endfunction

        function bit pool_exhausted();
            return int'(free_list_head) >= chtbl_pkg::NODES;
        endfunction

        // Apply one request word to the table copy and return its response.
        function chtbl_pkg::rsp_word_t apply_request(chtbl_pkg::req_word_t w);
            chtbl_pkg::rsp_word_t r;
            int                   b;
            int                   n;
            int                   cur;
            int                   prev;
            int                   steps;
            r.status = chtbl_pkg::STAT_NOT_FOUND;
            r.bucket = '0;
            b = int'(w.key % chtbl_pkg::BUCKETS);
            case (w.operation)
                chtbl_pkg::OP_INSERT:
                begin
                    if (int'(free_list_head) >= chtbl_pkg::NODES)
                    begin
                        r.status = chtbl_pkg::STAT_FULL;
                    end
                    else
                    begin
                        n = int'(free_list_head);
                        free_list_head    = link_of_node[n];
                        key_of_node[n]    = w.key;
                        link_of_node[n]   = head_of_bucket[b];
                        head_of_bucket[b] = chtbl_pkg::PTR_W'(n);
                        r.status = chtbl_pkg::STAT_OK;
                        r.bucket = chtbl_pkg::OUT_BKT_W'(b);
                    end
                end
                chtbl_pkg::OP_SEARCH, chtbl_pkg::OP_REMOVE:
                begin
                    prev  = -1;
                    cur   = int'(head_of_bucket[b]);
                    steps = 0;
                    while (cur < chtbl_pkg::NODES && steps < chtbl_pkg::NODES)
                    begin
                        if (key_of_node[cur] == w.key)
                            break;
                        prev = cur;
                        cur  = int'(link_of_node[cur]);
                        steps++;
                    end
                    if (cur < chtbl_pkg::NODES && steps < chtbl_pkg::NODES)
                    begin
                        if (w.operation == chtbl_pkg::OP_REMOVE)
                        begin
                            // unlink the first match, push it back on the free list
                            if (prev >= 0)
                                link_of_node[prev] = link_of_node[cur];
                            else
                                head_of_bucket[b] = link_of_node[cur];
                            link_of_node[cur] = free_list_head;
                            free_list_head    = chtbl_pkg::PTR_W'(cur);
                        end
                        r.status = chtbl_pkg::STAT_OK;
                        r.bucket = chtbl_pkg::OUT_BKT_W'(b);
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(chtbl_pkg::req_word_t w);
            awaited.push_back(apply_request(w));
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_response(chtbl_pkg::rsp_word_t got);
            chtbl_pkg::rsp_word_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word status %0d bucket %0d",
                                          got.status, got.bucket));
            end
            else
            begin
                want = awaited.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              got.status, want.status));
                if (got.bucket !== want.bucket)
                    report_mismatch($sformatf("bucket %0d, wanted %0d",
                                              got.bucket, want.bucket));
            end
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    chtbl_pkg::req_word_t req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    chtbl_pkg::rsp_word_t rsp_word;

    logic                        no_gaps = 1'b0;
    chain_scoreboard             board;
    logic [chtbl_pkg::KEY_W-1:0] recent_keys [$];

    chained_hash_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= no_gaps ? 1'b0 : ($urandom_range(0, 99) < 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp_word);
    end

    task automatic send_request(input logic [chtbl_pkg::OP_W-1:0] op,
                                input logic [chtbl_pkg::KEY_W-1:0] key);
        chtbl_pkg::req_word_t w;
        w.operation = op;
        w.key       = key;
        while (!no_gaps && $urandom_range(0, 99) < 36)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        board.note_request(w);
        if (op == chtbl_pkg::OP_INSERT)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
    endtask

    // Hold the sender until every response word is back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [chtbl_pkg::KEY_W-1:0] pick_key(int hot_pct, int reuse_pct);
        int roll;
        roll = $urandom_range(0, 99);
        // hot keys crowd a few buckets to build long chains
        if (roll < hot_pct)
            return chtbl_pkg::KEY_W'($urandom_range(0, 31) +
                                     chtbl_pkg::BUCKETS * $urandom_range(0, 7));
        if (roll < hot_pct + reuse_pct && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return chtbl_pkg::KEY_W'($urandom);
    endfunction

    function automatic logic [chtbl_pkg::OP_W-1:0] pick_op(int ins_pct, int srch_pct,
                                                           int rem_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            return chtbl_pkg::OP_INSERT;
        if (roll < ins_pct + srch_pct)
            return chtbl_pkg::OP_SEARCH;
        if (roll < ins_pct + srch_pct + rem_pct)
            return chtbl_pkg::OP_REMOVE;
        return OP_UNUSED;
    endfunction

    task automatic run_mixed(int count, int ins_pct, int srch_pct, int rem_pct);
        for (int i = 0; i < count; i++)
            send_request(pick_op(ins_pct, srch_pct, rem_pct), pick_key(30, 40));
    endtask

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed words
        send_request(chtbl_pkg::OP_SEARCH, 31'd0);
        send_request(chtbl_pkg::OP_REMOVE, 31'd0);
        send_request(chtbl_pkg::OP_INSERT, 31'd0);
        send_request(chtbl_pkg::OP_INSERT, 31'h7fff_ffff);
        send_request(chtbl_pkg::OP_SEARCH, 31'h7fff_ffff);
        send_request(chtbl_pkg::OP_INSERT, 31'd7);
        send_request(chtbl_pkg::OP_INSERT, chtbl_pkg::KEY_W'(7 + chtbl_pkg::BUCKETS));
        send_request(chtbl_pkg::OP_INSERT, chtbl_pkg::KEY_W'(7 + 2 * chtbl_pkg::BUCKETS));
        send_request(chtbl_pkg::OP_REMOVE, chtbl_pkg::KEY_W'(7 + chtbl_pkg::BUCKETS));
        send_request(chtbl_pkg::OP_SEARCH, 31'd7);
        send_request(chtbl_pkg::OP_SEARCH, chtbl_pkg::KEY_W'(7 + chtbl_pkg::BUCKETS));
        send_request(chtbl_pkg::OP_INSERT, 31'd5);
        send_request(chtbl_pkg::OP_INSERT, 31'd5);
        send_request(chtbl_pkg::OP_REMOVE, 31'd5);
        send_request(chtbl_pkg::OP_SEARCH, 31'd5);
        send_request(chtbl_pkg::OP_REMOVE, 31'd5);
        send_request(chtbl_pkg::OP_SEARCH, 31'd5);
        send_request(OP_UNUSED, 31'h7fff_ffff);
        send_request(OP_UNUSED, 31'd0);
        send_request(chtbl_pkg::OP_REMOVE, 31'h7fff_ffff);
        send_request(chtbl_pkg::OP_REMOVE, 31'd0);
        send_request(chtbl_pkg::OP_REMOVE, 31'd7);
        send_request(chtbl_pkg::OP_REMOVE, chtbl_pkg::KEY_W'(7 + 2 * chtbl_pkg::BUCKETS));
        wait_drained();

        run_mixed(500, 40, 30, 25);
        wait_drained();

        // fill the pool without gaps, then keep pushing past full
        no_gaps = 1'b1;
        while (!board.pool_exhausted())
            send_request(chtbl_pkg::OP_INSERT, pick_key(25, 25));
        run_mixed(30, 70, 25, 0);
        wait_drained();
        no_gaps = 1'b0;

        run_mixed(200, 10, 25, 60);
        wait_drained();

        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/chtbl_pkg.sv
rtl/chtbl_ram.sv
rtl/chtbl_ctrl.sv
rtl/chtbl_dpath.sv
rtl/chained_hash_table.sv
dv/testbench.sv
